### hdl/string_escape_decoder_macros.svh
// Assertion macros shared by the string escape decoder modules.
// The macros expect clk and arst_n to be visible in the module that uses them.
`ifndef STRING_ESCAPE_DECODER_MACROS_SVH
`define STRING_ESCAPE_DECODER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define SED_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define SED_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hdl/sed_pkg.sv
// Types, constants and helper functions of the string escape decoder.
// Used by sed_decode, sed_outbuf and string_escape_decoder.
package sed_pkg;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_END   = 2'd1;
	localparam logic [1:0] KIND_NLERR = 2'd2;

	localparam logic [7:0] QUOTE_RESET = 8'h22;
	localparam logic [7:0] CH_NL       = 8'h0a;
	localparam logic [7:0] CH_BSL      = 8'h5c;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'b0001,
		MODE_ESC  = 4'b0010,
		MODE_OCT1 = 4'b0100,
		MODE_OCT2 = 4'b1000
	} mode_t;

	typedef struct packed {
		logic [8:0] value;
		logic [1:0] kind;
		logic       last;
	} res_t;

	typedef struct packed {
		logic       v0;
		logic       v1;
		res_t       r0;
		res_t       r1;
		mode_t      nmode;
		logic [5:0] naccum;
	} dec_t;

	typedef struct packed {
		logic valid;
		logic esc;
		res_t res;
	} idle_t;

	function automatic logic is_octal(input logic [7:0] c);
		return c[7:3] == 5'b00110;
	endfunction

	function automatic logic [7:0] map_escape(input logic [7:0] c);
		logic [7:0] v;
		unique case (c)
			8'h6e:   v = 8'h0a;
			8'h74:   v = 8'h09;
			8'h62:   v = 8'h08;
			8'h72:   v = 8'h0d;
			8'h66:   v = 8'h0c;
			8'h61:   v = 8'h07;
			8'h76:   v = 8'h0b;
			8'h7a:   v = 8'h00;
			default: v = c;
		endcase
		return v;
	endfunction

	// Decoding of a character with no escape pending.
	function automatic idle_t decode_idle(input logic [7:0] c, input logic [7:0] quote);
		idle_t d;
		d.valid = 1'b1;
		d.esc = 1'b0;
		d.res.last = 1'b1;
		d.res.value = 9'd0;
		if (c == CH_NL) begin
			d.res.kind = KIND_NLERR;
		end else if (c == CH_BSL) begin
			d.valid = 1'b0;
			d.esc = 1'b1;
			d.res.kind = KIND_CHAR;
		end else if (c == quote) begin
			d.res.kind = KIND_END;
		end else begin
			d.res.kind = KIND_CHAR;
			d.res.value = {1'b0, c};
		end
		return d;
	endfunction

endpackage

### hdl/sed_decode.sv
// Combinational decoder: one character and the escape state give up to two results.
// Depends on sed_pkg.
module sed_decode (
	input  logic [7:0]    in_char,
	input  logic [7:0]    quote,
	input  sed_pkg::mode_t mode,
	input  logic [5:0]    accum,
	output sed_pkg::dec_t dec
);
	import sed_pkg::*;

	idle_t      id;
	logic       oct;
	logic [2:0] digit;

	assign id    = decode_idle(in_char, quote);
	assign oct   = is_octal(in_char);
	assign digit = in_char[2:0];

	always_comb begin
		dec.v0 = 1'b0;
		dec.v1 = 1'b0;
		dec.r0 = '{value: 9'd0, kind: KIND_CHAR, last: 1'b1};
		dec.r1 = '{value: 9'd0, kind: KIND_CHAR, last: 1'b1};
		dec.nmode = MODE_IDLE;
		dec.naccum = 6'd0;
		unique case (mode)
			MODE_ESC: begin
				if (oct) begin
					dec.nmode = MODE_OCT1;
					dec.naccum = {3'd0, digit};
				end else if (in_char != CH_NL) begin
					dec.v0 = 1'b1;
					dec.r0.value = {1'b0, map_escape(in_char)};
				end
			end
			MODE_OCT1, MODE_OCT2: begin
				if (oct) begin
					if (mode == MODE_OCT1) begin
						dec.nmode = MODE_OCT2;
						dec.naccum = {accum[2:0], digit};
					end else begin
						dec.v0 = 1'b1;
						dec.r0.value = {accum, digit};
					end
				end else begin
					dec.v0 = 1'b1;
					dec.r0.value = {3'd0, accum};
					dec.r0.last = !id.valid;
					dec.v1 = id.valid;
					dec.r1 = id.res;
					dec.nmode = id.esc ? MODE_ESC : MODE_IDLE;
				end
			end
			default: begin
				dec.v0 = id.valid;
				dec.r0 = id.res;
				dec.nmode = id.esc ? MODE_ESC : MODE_IDLE;
			end
		endcase
	end

endmodule

### hdl/sed_outbuf.sv
// Output register with one holding slot for the second result of a character.
// Depends on sed_pkg and string_escape_decoder_macros.svh.
`include "string_escape_decoder_macros.svh"
module sed_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sed_pkg::dec_t dec,
	output logic          ready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,  // out_value
	output logic [1:0]    m_tuser,  // out_kind
	output logic          m_tlast
);
	import sed_pkg::*;

	res_t out_q;
	res_t pend_q;
	logic out_valid_q;
	logic pend_valid_q;
	logic load;
	logic drain;

	assign drain = out_valid_q && m_tready;
	assign ready = !pend_valid_q && (!out_valid_q || m_tready);
	assign load  = push && dec.v0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q  <= 1'b1;
			pend_valid_q <= dec.v1;
		end else if (drain) begin
			out_valid_q  <= pend_valid_q;
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q  <= dec.r0;
			pend_q <= dec.r1;
		end else if (drain && pend_valid_q) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.value};
	assign m_tuser  = out_q.kind;
	assign m_tlast  = out_q.last;

	`SED_ASSERT_IMPLY(a_pend_behind_out, pend_valid_q, out_valid_q, "held result without output")
	`SED_ASSERT_IMPLY(a_marker_zero, out_valid_q && out_q.kind != KIND_CHAR,
		out_q.value == 9'd0, "marker with non-zero value")
	`SED_ASSERT_IMPLY(a_first_not_last, pend_valid_q, !out_q.last, "first of two marked last")

endmodule

### hdl/string_escape_decoder.sv
// An input character is registered, then its first result in the output register.
// Throughput: one character per cycle while the output accepts; after a two-result
// character, the next result-giving character waits until the holding slot drains.
// Reset clears the escape state, the octal value and all valid flags at once and loads
// the quote character with a double quote.
// Depends on sed_pkg, sed_decode, sed_outbuf and string_escape_decoder_macros.svh.
`include "string_escape_decoder_macros.svh"
module string_escape_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_data,  // quote_char
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_value
	output logic [1:0]  m_tuser,   // out_kind
	output logic        m_tlast
);
	import sed_pkg::*;

	logic [7:0] quote_q;
	mode_t      mode_q;
	logic [5:0] accum_q;
	logic [7:0] char_s1;
	logic       valid_s1;
	logic       ob_ready;
	logic       fire;
	dec_t       dec;

	sed_decode u_decode (
		.in_char (char_s1),
		.quote   (quote_q),
		.mode    (mode_q),
		.accum   (accum_q),
		.dec     (dec)
	);

	assign fire     = valid_s1 && (ob_ready || !dec.v0);
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quote_q  <= QUOTE_RESET;
			mode_q   <= MODE_IDLE;
			accum_q  <= 6'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				quote_q <= cfg_data;
			end
			if (fire) begin
				mode_q  <= dec.nmode;
				accum_q <= dec.naccum;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	sed_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (fire),
		.dec      (dec),
		.ready    (ob_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`SED_ASSERT_IMPLY(a_accum_clear, mode_q == MODE_IDLE || mode_q == MODE_ESC,
		accum_q == 6'd0, "octal value left over outside an octal run")
	`SED_ASSERT_IMPLY(a_second_needs_first, fire && dec.v1, dec.v0, "second result alone")
	`SED_ASSERT(a_kind_range, !m_tvalid || m_tuser != 2'd3, "undefined result kind")

endmodule
